### rtl/psnn_pkg.sv
// ----------------------------------------------------------------------------
// psnn_pkg: shared definitions for the point set nearest neighbor search
// Widths, field positions, operation codes, state types and the structs that
// link the sequencer, the distance unit and the point memory.
// ----------------------------------------------------------------------------
`default_nettype none

package psnn_pkg;

    // Store size and coordinate format.
    localparam int MAX_POINTS  = 64;
    localparam int COORD_WIDTH = 16;

    // Fixed field widths of the stream words.
    localparam int OPER_W   = 2;
    localparam int K_W      = 7;
    localparam int RADIUS_W = 17;
    localparam int PIDX_W   = 6;

    // Index and count widths that follow from the store size.
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int KC_W  = (K_W > CNT_W) ? K_W : CNT_W;

    // Distance arithmetic widths: a magnitude is wide enough for a
    // coordinate difference and for the radius, a distance adds a carry.
    localparam int MAG_W  = (COORD_WIDTH + 1 > RADIUS_W) ? COORD_WIDTH + 1 : RADIUS_W;
    localparam int OP_W   = MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 1;

    // One stored point: y in the upper half, x in the lower half.
    localparam int PT_W = 2 * COORD_WIDTH;

    // Input word layout, lowest bit first.
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + COORD_WIDTH;
    localparam int FIRST_BIT  = Y_LSB + COORD_WIDTH;
    localparam int K_LSB      = FIRST_BIT + 1;
    localparam int R_LSB      = K_LSB + K_W;
    localparam int S_FIELDS_W = R_LSB + RADIUS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Output word layout: the point index alone, padded to a byte.
    localparam int M_TDATA_W = ((PIDX_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    typedef enum logic [OPER_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_NEAREST = 2'd1,
        OP_KNN     = 2'd2,
        OP_RADIUS  = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RSQ_GO,
        S_RSQ_WAIT,
        S_READ,
        S_LAUNCH,
        S_CALC,
        S_EVAL,
        S_FINISH,
        S_EMPTY
    } seq_state_t;

    // Distance unit steps.
    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SQ_X,
        DS_SQ_Y,
        DS_SUM
    } dist_step_t;

    // Request to the distance unit: |xa-xb|^2 + |ya-yb|^2.
    typedef struct packed {
        logic                   start;
        logic signed [OP_W-1:0] xa;
        logic signed [OP_W-1:0] xb;
        logic signed [OP_W-1:0] ya;
        logic signed [OP_W-1:0] yb;
    } dist_req_t;

    // Response of the distance unit; dsq holds until the next request.
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] dsq;
    } dist_rsp_t;

    // Result word handed from the sequencer to the output register.
    typedef struct packed {
        logic              valid;
        logic [PIDX_W-1:0] idx;
        logic              found;
        logic              last;
    } emit_t;

    // Point memory access.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [PT_W-1:0]  wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/psnn_ram.sv
// ----------------------------------------------------------------------------
// psnn_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psnn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/psnn_dist_unit.sv
// ----------------------------------------------------------------------------
// psnn_dist_unit: shared squared distance unit
// Forms |xa-xb|^2 + |ya-yb|^2 with a single multiplier used twice, then adds
// the two squares in the steps DS_SQ_X, DS_SQ_Y and DS_SUM; done marks the result.
// ----------------------------------------------------------------------------
`default_nettype none

module psnn_dist_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire psnn_pkg::dist_req_t  req,
    output psnn_pkg::dist_rsp_t       rsp
);
    import psnn_pkg::*;

    dist_step_t             step_reg, step_next;
    logic [MAG_W-1:0]       opnd_reg, opnd_next;
    logic [MAG_W-1:0]       opnd2_reg, opnd2_next;
    logic [SQ_W-1:0]        prod_reg, prod_next;
    logic [SQ_W-1:0]        acc_reg, acc_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic                   done_reg, done_next;
    logic [SQ_W-1:0]        square;
    logic signed [OP_W-1:0] dx, dy;

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [OP_W-1:0] d);
        logic signed [OP_W-1:0] neg;
        neg = -d;
        return d[OP_W-1] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    // Differences of the operand pairs; their magnitudes fit MAG_W bits.
    assign dx = req.xa - req.xb;
    assign dy = req.ya - req.yb;

    // The one multiplier of the unit.
    assign square = opnd_reg * opnd_reg;

    // Step sequence.
    always_comb begin
        step_next = step_reg;
        unique case (step_reg)
            DS_IDLE: begin
                if (req.start) begin
                    step_next = DS_SQ_X;
                end
            end
            DS_SQ_X: step_next = DS_SQ_Y;
            DS_SQ_Y: step_next = DS_SUM;
            DS_SUM:  step_next = DS_IDLE;
        endcase
    end

    // Datapath per step.
    always_comb begin
        opnd_next  = opnd_reg;
        opnd2_next = opnd2_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        dist_next  = dist_reg;
        done_next  = 1'b0;
        unique case (step_reg)
            DS_IDLE: begin
                if (req.start) begin
                    opnd_next  = magnitude(dx);
                    opnd2_next = magnitude(dy);
                end
            end
            DS_SQ_X: begin
                prod_next = square;
                opnd_next = opnd2_reg;
            end
            DS_SQ_Y: begin
                acc_next  = prod_reg;
                prod_next = square;
            end
            DS_SUM: begin
                dist_next = DIST_W'(acc_reg) + DIST_W'(prod_reg);
                done_next = 1'b1;
            end
        endcase
    end

    // Control state is reset; operands and products are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= DS_IDLE;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        opnd_reg  <= opnd_next;
        opnd2_reg <= opnd2_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        dist_reg  <= dist_next;
    end

    assign rsp.done = done_reg;
    assign rsp.dsq  = dist_reg;

endmodule

`default_nettype wire

### rtl/psnn_seq.sv
// ----------------------------------------------------------------------------
// psnn_seq: load and query sequencer
// Stores points, then for each query walks the stored points through the
// shared distance unit. Nearest takes one pass; k-nearest takes one pass per
// answer, each pass picking the smallest (distance, index) pair above the
// one picked before; radius search reports hits one behind, so the final
// hit can carry the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module psnn_seq (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire psnn_pkg::op_t                      op,
    input  wire logic signed [psnn_pkg::COORD_WIDTH-1:0] x_coord,
    input  wire logic signed [psnn_pkg::COORD_WIDTH-1:0] y_coord,
    input  wire logic                               first_point,
    input  wire logic [psnn_pkg::K_W-1:0]           k_count,
    input  wire logic [psnn_pkg::RADIUS_W-1:0]      radius,
    output psnn_pkg::ram_req_t                      ram_req,
    input  wire logic [psnn_pkg::PT_W-1:0]          ram_rdata,
    output psnn_pkg::dist_req_t                     dist_req,
    input  wire psnn_pkg::dist_rsp_t                dist_rsp,
    output psnn_pkg::emit_t                         emit,
    input  wire logic                               out_free
);
    import psnn_pkg::*;

    seq_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    op_t                      op_reg, op_next;
    logic signed [COORD_WIDTH-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [RADIUS_W-1:0]      radius_reg, radius_next;
    logic [CNT_W-1:0]         want_reg, want_next;
    logic [CNT_W-1:0]         pass_reg, pass_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [DIST_W-1:0]        r2_reg, r2_next;
    logic                     have_reg, have_next;
    logic [DIST_W-1:0]        best_d_reg, best_d_next;
    logic [IDX_W-1:0]         best_i_reg, best_i_next;
    logic [DIST_W-1:0]        prev_d_reg, prev_d_next;
    logic [IDX_W-1:0]         prev_i_reg, prev_i_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]         pend_i_reg, pend_i_next;

    logic                     accept;
    logic                     room;
    logic                     last_pt;
    logic                     hit;
    logic                     above_prev;
    logic                     better;
    logic                     eval_stall;
    logic                     knn_last;
    logic [KC_W-1:0]          k_ext, n_ext;
    logic [CNT_W-1:0]         want_calc;
    logic signed [COORD_WIDTH-1:0] px, py;

    // Shared conditions.
    assign accept     = s_valid && (state_reg == S_IDLE);
    assign room       = count_reg < CNT_W'(MAX_POINTS);
    assign last_pt    = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign hit        = dist_rsp.dsq <= r2_reg;
    assign above_prev = (dist_rsp.dsq > prev_d_reg)
                     || ((dist_rsp.dsq == prev_d_reg) && (idx_reg > prev_i_reg));
    assign better     = ((op_reg != OP_KNN) || (pass_reg == '0) || above_prev)
                     && (!have_reg || (dist_rsp.dsq < best_d_reg));
    assign eval_stall = (op_reg == OP_RADIUS) && hit && pend_valid_reg && !out_free;
    assign knn_last   = (pass_reg + CNT_W'(1)) == want_reg;
    assign k_ext      = KC_W'(k_count);
    assign n_ext      = KC_W'(count_reg);
    assign want_calc  = (k_ext < n_ext) ? CNT_W'(k_ext) : count_reg;
    assign px         = ram_rdata[COORD_WIDTH-1:0];
    assign py         = ram_rdata[PT_W-1:COORD_WIDTH];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_LOAD:    state_next = S_IDLE;
                        OP_NEAREST: state_next = (count_reg == '0) ? S_EMPTY : S_READ;
                        OP_KNN:     state_next = (want_calc == '0) ? S_EMPTY : S_READ;
                        OP_RADIUS:  state_next = S_RSQ_GO;
                    endcase
                end
            end
            S_RSQ_GO: state_next = S_RSQ_WAIT;
            S_RSQ_WAIT: begin
                if (dist_rsp.done) begin
                    state_next = (count_reg == '0) ? S_FINISH : S_READ;
                end
            end
            S_READ:   state_next = S_LAUNCH;
            S_LAUNCH: state_next = S_CALC;
            S_CALC: begin
                if (dist_rsp.done) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!eval_stall) begin
                    state_next = last_pt ? S_FINISH : S_READ;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = ((op_reg == OP_KNN) && !knn_last) ? S_READ : S_IDLE;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: handshake, memory access, distance requests and result words.
    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        ram_req.we    = accept && (op == OP_LOAD) && (first_point || room);
        ram_req.waddr = first_point ? '0 : count_reg[IDX_W-1:0];
        ram_req.wdata = {y_coord, x_coord};
        ram_req.raddr = idx_reg;

        dist_req.start = (state_reg == S_RSQ_GO) || (state_reg == S_LAUNCH);
        if (state_reg == S_RSQ_GO) begin
            dist_req.xa = OP_W'(radius_reg);
            dist_req.xb = '0;
            dist_req.ya = '0;
            dist_req.yb = '0;
        end else begin
            dist_req.xa = OP_W'(qx_reg);
            dist_req.xb = OP_W'(px);
            dist_req.ya = OP_W'(qy_reg);
            dist_req.yb = OP_W'(py);
        end

        emit = '0;
        unique case (state_reg)
            S_EVAL: begin
                // A new hit releases the one held back, which is then not last.
                if ((op_reg == OP_RADIUS) && hit && pend_valid_reg && out_free) begin
                    emit.valid = 1'b1;
                    emit.idx   = PIDX_W'(pend_i_reg);
                    emit.found = 1'b1;
                    emit.last  = 1'b0;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    if (op_reg == OP_RADIUS) begin
                        // With no hit held back this is the empty answer at index zero.
                        emit.idx   = pend_valid_reg ? PIDX_W'(pend_i_reg) : '0;
                        emit.found = pend_valid_reg;
                        emit.last  = 1'b1;
                    end else begin
                        emit.idx   = PIDX_W'(best_i_reg);
                        emit.found = 1'b1;
                        emit.last  = (op_reg == OP_KNN) ? knn_last : 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    emit.last  = 1'b1;
                end
            end
            default: emit = '0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        count_next      = count_reg;
        op_next         = op_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        radius_next     = radius_reg;
        want_next       = want_reg;
        pass_next       = pass_reg;
        idx_next        = idx_reg;
        r2_next         = r2_reg;
        have_next       = have_reg;
        best_d_next     = best_d_reg;
        best_i_next     = best_i_reg;
        prev_d_next     = prev_d_reg;
        prev_i_next     = prev_i_reg;
        pend_valid_next = pend_valid_reg;
        pend_i_next     = pend_i_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (op == OP_LOAD) begin
                        // A first point restarts the set; a full set drops loads.
                        if (first_point) begin
                            count_next = CNT_W'(1);
                        end else if (room) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else begin
                        op_next         = op;
                        qx_next         = x_coord;
                        qy_next         = y_coord;
                        radius_next     = radius;
                        want_next       = want_calc;
                        pass_next       = '0;
                        idx_next        = '0;
                        have_next       = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            S_RSQ_WAIT: begin
                if (dist_rsp.done) begin
                    r2_next = dist_rsp.dsq;
                end
            end
            S_EVAL: begin
                if (!eval_stall) begin
                    if (op_reg == OP_RADIUS) begin
                        if (hit) begin
                            pend_valid_next = 1'b1;
                            pend_i_next     = idx_reg;
                        end
                    end else if (better) begin
                        have_next   = 1'b1;
                        best_d_next = dist_rsp.dsq;
                        best_i_next = idx_reg;
                    end
                    if (!last_pt) begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_FINISH: begin
                // Set up the next k-nearest pass above the pair just reported.
                if (out_free && (op_reg == OP_KNN) && !knn_last) begin
                    prev_d_next = best_d_reg;
                    prev_i_next = best_i_reg;
                    pass_next   = pass_reg + CNT_W'(1);
                    have_next   = 1'b0;
                    idx_next    = '0;
                end
            end
            default: begin
                have_next = have_reg;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            have_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            have_reg       <= have_next;
            pend_valid_reg <= pend_valid_next;
        end
        op_reg     <= op_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        radius_reg <= radius_next;
        want_reg   <= want_next;
        pass_reg   <= pass_next;
        idx_reg    <= idx_next;
        r2_reg     <= r2_next;
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        prev_d_reg <= prev_d_next;
        prev_i_reg <= prev_i_next;
        pend_i_reg <= pend_i_next;
    end

endmodule

`default_nettype wire

### rtl/point_set_nearest_neighbor_search.sv
// ----------------------------------------------------------------------------
// point_set_nearest_neighbor_search: brute-force nearest neighbor search
// Stores up to MAX_POINTS 2-D points and answers nearest, k-nearest and
// radius queries by scanning every stored point.
//
//   channel  dir  tdata (low bit first)                      tuser       tlast
//   s_       in   x, y, first_point, k_count, radius, pad    operation   -
//   m_       out  point_index, pad                           found       last_result
//
// A load keeps the input side ready and can be followed at once by the next word.
// A query scans the stored points through one shared distance unit: radius
// and nearest take one pass, k-nearest takes min(k_count, count) passes.
// The input side is not ready while a query runs; results leave through one
// output register, and a stalled m_tready holds the scan.
// aresetn empties the point set; the point memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module point_set_nearest_neighbor_search (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // x_coord, y_coord, first_point, k_count, radius, zero pad
    input  wire logic [psnn_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  wire logic [psnn_pkg::OPER_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // point_index, zero pad
    output logic [psnn_pkg::M_TDATA_W-1:0]        m_tdata,
    // found
    output logic                                  m_tuser,
    // last_result
    output logic                                  m_tlast
);
    import psnn_pkg::*;

    ram_req_t          ram_req;
    logic [PT_W-1:0]   ram_rdata;
    dist_req_t         dist_req;
    dist_rsp_t         dist_rsp;
    emit_t             emit;
    logic              out_free;
    logic              m_valid_reg, m_valid_next;
    logic [PIDX_W-1:0] m_idx_reg;
    logic              m_found_reg;
    logic              m_last_reg;

    // Sequencer with the input word unpacked.
    psnn_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .op          (op_t'(s_tuser)),
        .x_coord     (s_tdata[X_LSB +: COORD_WIDTH]),
        .y_coord     (s_tdata[Y_LSB +: COORD_WIDTH]),
        .first_point (s_tdata[FIRST_BIT]),
        .k_count     (s_tdata[K_LSB +: K_W]),
        .radius      (s_tdata[R_LSB +: RADIUS_W]),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .dist_req    (dist_req),
        .dist_rsp    (dist_rsp),
        .emit        (emit),
        .out_free    (out_free)
    );

    // Point memory, one {y, x} entry per stored point.
    psnn_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Shared squared distance unit.
    psnn_dist_unit u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dist_req),
        .rsp     (dist_rsp)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free     = !m_valid_reg || m_tready;
    assign m_valid_next = emit.valid ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (emit.valid) begin
            m_idx_reg   <= emit.idx;
            m_found_reg <= emit.found;
            m_last_reg  <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_idx_reg);
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### rtl/psnn_checker.sv
// ----------------------------------------------------------------------------
// psnn_checker: port-level checks for the nearest neighbor search
// Watches the stream ports of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module psnn_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [psnn_pkg::OPER_W-1:0]      s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [psnn_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                             m_tuser,
    input wire logic                             m_tlast
);
    import psnn_pkg::*;

    // After reset no word is pending and the input side is open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // An empty answer is always the only, hence last, word of its query.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty answer without last flag");

    // A query keeps the input side closed in the following cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_LOAD) |=> !s_tready)
        else $error("input accepted right after a query");

endmodule

bind point_set_nearest_neighbor_search psnn_checker u_psnn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### test/point_set_nearest_neighbor_search_tb.sv
// ----------------------------------------------------------------------------
// point_set_nearest_neighbor_search_tb: self-checking bench for the point search
// Loads small point sets, and twice a full one, then fires nearest, k-nearest and
// radius queries at them. Each result word is checked against a typed answer or a
// behavioral search over a private copy of the point set. A short table of directed words
// comes first, then random point sets under several idle and stall patterns.
// ----------------------------------------------------------------------------
module point_set_nearest_neighbor_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psnn_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 50_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_WORDS  = 70;
    localparam int NUM_DIRECTED = 24;

    // One result word as the search should produce it.
    typedef struct packed {
        logic [PIDX_W-1:0] idx;
        logic              found;
        logic              last;
    } neighbor_t;

    // One input word, with an optional result typed in by hand.
    typedef struct packed {
        op_t                           op;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          first;
        logic [K_W-1:0]                k;
        logic [RADIUS_W-1:0]           r;
        logic                          typed;
        neighbor_t                     answer;
    } stim_row_t;

    localparam neighbor_t NO_MATCH = '{idx: '0, found: 1'b0, last: 1'b1};

    // Directed words. Nearest rows on the first set have obvious answers:
    // ties at the origin go to the lower index.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{OP_NEAREST, 16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd0,      1'b1, NO_MATCH},
        '{OP_KNN,     16'sh0000, 16'sh0000, 1'b0, 7'd64, 17'd0,      1'b1, NO_MATCH},
        '{OP_RADIUS,  16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd131071, 1'b1, NO_MATCH},
        '{OP_LOAD,    16'sh8000, 16'sh8000, 1'b1, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_LOAD,    16'sh7fff, 16'sh7fff, 1'b0, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_LOAD,    16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_LOAD,    16'sh8000, 16'sh7fff, 1'b0, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_LOAD,    16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_NEAREST, 16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd0,      1'b1, '{6'd2, 1'b1, 1'b1}},
        '{OP_NEAREST, 16'sh7fff, 16'sh7fff, 1'b0, 7'd0,  17'd0,      1'b1, '{6'd1, 1'b1, 1'b1}},
        '{OP_NEAREST, 16'sh8000, 16'sh8000, 1'b0, 7'd0,  17'd0,      1'b1, '{6'd0, 1'b1, 1'b1}},
        '{OP_KNN,     16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd0,      1'b1, NO_MATCH},
        '{OP_KNN,     16'sh0000, 16'sh0000, 1'b0, 7'd64, 17'd0,      1'b0, NO_MATCH},
        '{OP_KNN,     16'shffff, 16'shffff, 1'b0, 7'd3,  17'd0,      1'b0, NO_MATCH},
        '{OP_RADIUS,  16'sh0000, 16'sh0000, 1'b0, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_RADIUS,  16'sh0001, 16'sh0001, 1'b0, 7'd0,  17'd0,      1'b1, NO_MATCH},
        '{OP_RADIUS,  16'sh8000, 16'sh7fff, 1'b0, 7'd0,  17'd131071, 1'b0, NO_MATCH},
        '{OP_RADIUS,  16'sh7fff, 16'sh8000, 1'b0, 7'd0,  17'd65536,  1'b0, NO_MATCH},
        '{OP_LOAD,    16'sh1234, 16'shedcb, 1'b1, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_NEAREST, 16'sh8000, 16'sh7fff, 1'b0, 7'd0,  17'd0,      1'b1, '{6'd0, 1'b1, 1'b1}},
        '{OP_KNN,     16'sh1234, 16'shedcb, 1'b0, 7'd2,  17'd0,      1'b0, NO_MATCH},
        '{OP_RADIUS,  16'sh1234, 16'shedcb, 1'b0, 7'd0,  17'd1,      1'b0, NO_MATCH},
        '{OP_LOAD,    16'sh7ff0, 16'sh0010, 1'b0, 7'd0,  17'd0,      1'b0, NO_MATCH},
        '{OP_NEAREST, 16'sh7fff, 16'sh0010, 1'b0, 7'd0,  17'd0,      1'b1, '{6'd1, 1'b1, 1'b1}}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [OPER_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Private copy of the point set.
    logic signed [COORD_WIDTH-1:0] pt_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] pt_y [MAX_POINTS];
    int                            pt_count = 0;

    neighbor_t neighbor_q [$];
    int        fail_count     = 0;
    int        words_sent     = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_req       = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;

    point_set_nearest_neighbor_search DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Append one expected result word at the tail of the queue.
    task automatic expect_word(input neighbor_t w);
        neighbor_q.insert(neighbor_q.size(), w);
    endtask

    // Apply one word to the point copy and queue the result words it causes.
    task automatic search_points(input stim_row_t row);
        longint dsq [MAX_POINTS];
        bit     taken [MAX_POINTS];
        longint dx;
        longint dy;
        longint r_sq;
        int     n;
        int     want;
        int     best;
        int     hits;
        n = pt_count;
        if (row.op == OP_LOAD) begin
            if (row.first)
                pt_count = 0;
            // A load into a full store without first_point is dropped.
            if (pt_count < MAX_POINTS) begin
                pt_x[pt_count] = row.x;
                pt_y[pt_count] = row.y;
                pt_count++;
            end
            return;
        end
        for (int i = 0; i < n; i++) begin
            dx = longint'(row.x) - longint'(pt_x[i]);
            dy = longint'(row.y) - longint'(pt_y[i]);
            dsq[i] = dx * dx + dy * dy;
            taken[i] = 1'b0;
        end
        hits = 0;
        if (row.op == OP_RADIUS) begin
            r_sq = longint'(row.r) * longint'(row.r);
            for (int i = 0; i < n; i++) begin
                if (dsq[i] <= r_sq) begin
                    expect_word('{idx: PIDX_W'(i), found: 1'b1, last: 1'b0});
                    hits++;
                end
            end
            if (hits > 0)
                neighbor_q[neighbor_q.size() - 1].last = 1'b1;
        end else begin
            // Nearest is a single selection pass; k-nearest repeats it.
            if (row.op == OP_NEAREST)
                want = (n > 0) ? 1 : 0;
            else
                want = (int'(row.k) < n) ? int'(row.k) : n;
            for (int j = 0; j < want; j++) begin
                best = -1;
                for (int i = 0; i < n; i++) begin
                    if (!taken[i] && (best < 0 || dsq[i] < dsq[best]))
                        best = i;
                end
                taken[best] = 1'b1;
                expect_word('{idx: PIDX_W'(best), found: 1'b1,
                              last: (j == want - 1)});
            end
            hits = want;
        end
        if (hits == 0)
            expect_word(NO_MATCH);
    endtask

    // Offer one word, wait for its handshake, then record what it should cause.
    task automatic send_item(input stim_row_t row);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[X_LSB +: COORD_WIDTH] = row.x;
        word[Y_LSB +: COORD_WIDTH] = row.y;
        word[FIRST_BIT]            = row.first;
        word[K_LSB +: K_W]         = row.k;
        word[R_LSB +: RADIUS_W]    = row.r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
        if (row.typed)
            expect_word(row.answer);
        else
            search_points(row);
    endtask

    // Stop offering words until every queued result word has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (neighbor_q.size() != 0);
    endtask

    // Coordinates: anywhere, in a tight cluster, or at the corners of the range.
    function automatic logic signed [COORD_WIDTH-1:0] pick_coord(
        input int style, input logic signed [COORD_WIDTH-1:0] center);
        case (style)
            0: return COORD_WIDTH'($urandom);
            1: return center + COORD_WIDTH'($urandom_range(0, 63)) - COORD_WIDTH'(32);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh8001;
                    3: return 16'sh7ffe;
                    default: return 16'sh0000;
                endcase
            end
        endcase
    endfunction

    // Random query word, with coordinates picked in the given style around the given center.
    function automatic stim_row_t random_query(input int style,
        input logic signed [COORD_WIDTH-1:0] cx, input logic signed [COORD_WIDTH-1:0] cy);
        stim_row_t row;
        row        = '0;
        row.answer = NO_MATCH;
        row.op     = op_t'($urandom_range(1, 3));
        row.x      = pick_coord(style, cx);
        row.y      = pick_coord(style, cy);
        row.first  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: row.k = 7'd64;
            1: row.k = 7'd0;
            2, 3: row.k = K_W'($urandom_range(0, 64));
            default: row.k = K_W'($urandom_range(1, (pt_count < 63) ? pt_count + 1 : 64));
        endcase
        case ($urandom_range(0, 7))
            0: row.r = RADIUS_W'($urandom_range(0, 131071));
            1: row.r = '0;
            2: row.r = 17'd131071;
            default: row.r = (style == 1) ? RADIUS_W'($urandom_range(0, 96))
                                          : RADIUS_W'($urandom_range(0, 65535));
        endcase
        return row;
    endfunction

    // A small point set, mostly restarted, followed by a few queries.
    task automatic run_scenario();
        stim_row_t                     row;
        int                            style;
        int                            npts;
        bit                            restart;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        style   = $urandom_range(0, 2);
        cx      = COORD_WIDTH'($urandom);
        cy      = COORD_WIDTH'($urandom);
        npts    = $urandom_range(0, 8);
        restart = (pt_count + npts > 12) || ($urandom_range(0, 3) != 0);
        row     = '0;
        for (int i = 0; i < npts; i++) begin
            row.op     = OP_LOAD;
            row.answer = NO_MATCH;
            row.typed  = 1'b0;
            // Now and then repeat the previous point to make distance ties.
            if (i == 0 || $urandom_range(0, 7) != 0) begin
                row.x = pick_coord(style, cx);
                row.y = pick_coord(style, cy);
            end
            row.first = (i == 0) && restart;
            row.k     = K_W'($urandom_range(0, 64));
            row.r     = RADIUS_W'($urandom_range(0, 131071));
            send_item(row);
        end
        repeat ($urandom_range(1, 5))
            send_item(random_query(style, cx, cy));
    endtask

    // Fill the store past capacity, then query the full set.
    task automatic fill_store(input bit deep_knn);
        stim_row_t                     row;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        cx  = COORD_WIDTH'($urandom);
        cy  = COORD_WIDTH'($urandom);
        row = '0;
        for (int i = 0; i < MAX_POINTS + 3; i++) begin
            row.op     = OP_LOAD;
            row.answer = NO_MATCH;
            row.x      = pick_coord($urandom_range(0, 1), cx);
            row.y      = pick_coord($urandom_range(0, 1), cy);
            row.first  = (i == 0);
            row.k      = K_W'($urandom_range(0, 64));
            row.r      = RADIUS_W'($urandom_range(0, 131071));
            send_item(row);
        end
        row.x  = pick_coord(1, cx);
        row.y  = pick_coord(1, cy);
        row.op = OP_NEAREST;
        send_item(row);
        row.op = OP_RADIUS;
        row.r  = 17'd40;
        send_item(row);
        row.r  = 17'd131071;
        send_item(row);
        row.op = OP_KNN;
        row.k  = 7'd6;
        send_item(row);
        if (deep_knn) begin
            row.k = 7'd64;
            send_item(row);
        end
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge aclk) begin
        neighbor_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (neighbor_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result word idx=%0d found=%b last=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
            end else begin
                want = neighbor_q.pop_front();
                if (m_tdata !== M_TDATA_W'(want.idx) || m_tuser !== want.found ||
                    m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word expected idx=%0d found=%b last=%b, %s",
                                 $realtime, want.idx, want.found, want.last,
                                 $sformatf("got idx=%0d found=%b last=%b",
                                           m_tdata, m_tuser, m_tlast));
                end
            end
        end
        // A long hold-off requested by the stimulus counts down here.
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("point_set_nearest_neighbor_search: mismatch");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(DIRECTED_ROWS[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (phase == 0)
                fill_store(1'b1);
            if (phase == 3)
                fill_store(1'b0);
            if (phase == 2) begin
                // Receiver holds off while words keep coming, so the input stalls.
                hold_req++;
                send_item(random_query(1, pt_x[0], pt_y[0]));
            end
            for (int target = words_sent + PHASE_WORDS; words_sent < target; ) begin
                run_scenario();
                if (phase == 1 && words_sent >= target - PHASE_WORDS / 2 &&
                    words_sent < target - PHASE_WORDS / 2 + 8)
                    drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && neighbor_q.size() == 0)
            $display("point_set_nearest_neighbor_search: match");
        else
            $display("point_set_nearest_neighbor_search: mismatch");
        $finish;
    end

endmodule
